/* sv/edc_pkg.sv */
// Shared types and constants for the edit distance / similarity core.
// No dependencies; imported by every module of the block.
package edc_pkg;

    // Width of one string code unit
    localparam int CODE_W = 16;

    // Similarity percent scale and the score given when a string is empty
    localparam int PCT = 100;
    localparam logic signed [7:0] SCORE_FULL  = 8'sd100;
    localparam logic signed [7:0] SCORE_EMPTY = -8'sd1;

    // Request command codes
    typedef enum logic [1:0] {
        CMD_FIRST  = 2'd0,
        CMD_SECOND = 2'd1,
        CMD_FINISH = 2'd2
    } t_cmd;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_COL  = 4'b0010,
        S_FIN  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

endpackage

/* sv/edc_step.sv */
// One Levenshtein cell update: substitution cost and minimum of three candidates.
// Depends on edc_pkg for the code unit width.
module edc_step #(
    parameter int DW = 6
) (
    input  logic [DW-1:0]              i_left,
    input  logic [DW-1:0]              i_up,
    input  logic [DW-1:0]              i_diag,
    input  logic [edc_pkg::CODE_W-1:0] i_stored,
    input  logic [edc_pkg::CODE_W-1:0] i_unit,
    output logic [DW-1:0]              o_best
);
    import edc_pkg::*;

    logic [DW:0] ins_c;
    logic [DW:0] del_c;
    logic [DW:0] sub_c;
    logic [DW:0] min_ab;
    logic [DW:0] min_all;

    // Form the three candidates one bit wider, then take the minimum
    always_comb begin
        ins_c   = {1'b0, i_left} + (DW+1)'(1);
        del_c   = {1'b0, i_up} + (DW+1)'(1);
        sub_c   = {1'b0, i_diag} + ((i_stored == i_unit) ? (DW+1)'(0) : (DW+1)'(1));
        min_ab  = (ins_c < del_c) ? ins_c : del_c;
        min_all = (min_ab < sub_c) ? min_ab : sub_c;
        o_best  = min_all[DW-1:0];
    end

endmodule

/* sv/edc_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on edc_pkg only by house convention; used for the similarity quotient.
module edc_div #(
    parameter int NUM_W = 12,
    parameter int DEN_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    import edc_pkg::*;

    localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_run;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   sh_rem;
    logic             q_bit;
    logic [DEN_W:0]   diff;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        sh_rem = {r_rem, r_quo[NUM_W-1]};
        diff   = sh_rem - {1'b0, r_den};
        q_bit  = (sh_rem >= {1'b0, r_den});
    end

    // Control: run for NUM_W steps, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_run) begin
            r_rem <= q_bit ? diff[DEN_W-1:0] : sh_rem[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* sv/edit_distance_similarity_core.sv */
// Edit distance / similarity core: top level with sequencer and the string
// and DP column memories. Depends on edc_pkg, edc_step and edc_div.
//
// Usage: present a request on i_command / i_code_unit with start high while
// busy is low. Command FIRST appends a unit to the first string; it is
// ignored once a SECOND request has been taken. Command SECOND appends a
// unit to the second string and sweeps the DP column through the shared cell
// unit one stored entry per cycle, keeping busy high until the sweep ends.
// Command FINISH reads the final column entry, then, unless a string is empty,
// runs the serial divider; the result appears on o_distance / o_score /
// o_overflow with o_done high for exactly one cycle. The block then returns
// to its cleared state and can take the next request in the same cycle that
// the result is shown. Units past MAX_LEN are dropped and flagged; reset
// (synchronous, active low) clears lengths, flags and the column's valid
// bits. The receiver cannot stall: o_done marks each result only once.
module edit_distance_similarity_core #(
    parameter int MAX_LEN = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [1:0]                 i_command,
    input  logic [edc_pkg::CODE_W-1:0] i_code_unit,
    output logic                       busy,
    output logic                       o_done,
    output logic [5:0]                 o_distance,
    output logic signed [7:0]          o_score,
    output logic                       o_overflow
);
    import edc_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int NW = $clog2(PCT * MAX_LEN + 1);

    // Memories
    logic [CODE_W-1:0] fs_mem [0:MAX_LEN-1];
    logic [LW-1:0]     dp_mem [0:MAX_LEN];

    // Control and datapath registers
    t_state             r_state, n_state;
    logic [LW-1:0]      r_n, n_n;
    logic [LW-1:0]      r_m, n_m;
    logic               r_phase, n_phase;
    logic               r_ovf, n_ovf;
    logic [CODE_W-1:0]  r_unit;
    logic [LW-1:0]      r_left, n_left;
    logic [LW-1:0]      r_diag, n_diag;
    logic [LW-1:0]      r_rd_addr;
    logic               r_rd_vld;
    logic [LW-1:0]      r_dp_q;
    logic [CODE_W-1:0]  r_fs_q;
    logic [MAX_LEN:0]   r_dp_vld;
    logic               r_done;
    logic [5:0]         r_distance;
    logic signed [7:0]  r_score;
    logic               r_overflow;

    // Combinational controls
    logic               accept;
    logic               clear_all;
    logic [LW-1:0]      rd_addr;
    logic [AW-1:0]      fs_ra;
    logic               fs_we;
    logic               dp_we;
    logic [LW-1:0]      dp_wd;
    logic               unit_ld;
    logic [LW-1:0]      eff;
    logic [LW-1:0]      best;
    logic [LW-1:0]      longer;
    logic               div_start;
    logic [NW-1:0]      div_num;
    logic               div_done;
    logic [NW-1:0]      div_quot;
    logic               dist_ld;
    logic               score_ld;
    logic signed [7:0]  score_val;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Column entry as read: unwritten entries hold their own index
    assign eff    = r_rd_vld ? r_dp_q : r_rd_addr;
    assign longer = (r_n > r_m) ? r_n : r_m;

    // Shared cell update
    edc_step #(.DW(LW)) u_step (
        .i_left   (r_left),
        .i_up     (eff),
        .i_diag   (r_diag),
        .i_stored (r_fs_q),
        .i_unit   (r_unit),
        .o_best   (best)
    );

    // Serial divider for 100 * distance / longer length
    edc_div #(.NUM_W(NW), .DEN_W(LW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (longer),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign div_num = NW'(PCT * eff);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_m       = r_m;
        n_phase   = r_phase;
        n_ovf     = r_ovf;
        n_left    = r_left;
        n_diag    = r_diag;
        rd_addr   = r_rd_addr;
        fs_we     = 1'b0;
        dp_we     = 1'b0;
        dp_wd     = best;
        unit_ld   = 1'b0;
        div_start = 1'b0;
        dist_ld   = 1'b0;
        score_ld  = 1'b0;
        score_val = SCORE_EMPTY;
        clear_all = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        CMD_FIRST: begin
                            if (!r_phase) begin
                                if (r_n == LW'(MAX_LEN)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    fs_we = 1'b1;
                                    n_n   = r_n + LW'(1);
                                end
                            end
                        end
                        CMD_SECOND: begin
                            n_phase = 1'b1;
                            if (r_m == LW'(MAX_LEN)) begin
                                n_ovf = 1'b1;
                            end else begin
                                unit_ld = 1'b1;
                                rd_addr = '0;
                                n_state = S_COL;
                            end
                        end
                        CMD_FINISH: begin
                            rd_addr = r_n;
                            n_state = S_FIN;
                        end
                        default: begin
                            // reserved code: drop the request
                        end
                    endcase
                end
            end
            S_COL: begin
                // Write back the entry just read, advance the read pointer
                dp_we  = 1'b1;
                dp_wd  = (r_rd_addr == '0) ? LW'(r_m + LW'(1)) : best;
                n_left = dp_wd;
                n_diag = eff;
                if (r_rd_addr < r_n) begin
                    rd_addr = r_rd_addr + LW'(1);
                end else begin
                    n_m     = r_m + LW'(1);
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                dist_ld = 1'b1;
                if (r_n == '0 || r_m == '0) begin
                    score_ld  = 1'b1;
                    score_val = SCORE_EMPTY;
                    clear_all = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    score_ld  = 1'b1;
                    score_val = (div_quot >= NW'(PCT)) ? 8'sd0
                                                       : SCORE_FULL - 8'(div_quot);
                    clear_all = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (clear_all) begin
            n_n     = '0;
            n_m     = '0;
            n_phase = 1'b0;
            n_ovf   = 1'b0;
        end
    end

    assign fs_ra = (rd_addr == '0) ? '0 : AW'(rd_addr - LW'(1));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_n        <= '0;
            r_m        <= '0;
            r_phase    <= 1'b0;
            r_ovf      <= 1'b0;
            r_done     <= 1'b0;
            r_dp_vld   <= '0;
        end else begin
            r_state    <= n_state;
            r_n        <= n_n;
            r_m        <= n_m;
            r_phase    <= n_phase;
            r_ovf      <= n_ovf;
            r_done     <= score_ld;
            if (clear_all) begin
                r_dp_vld <= '0;
            end else if (dp_we) begin
                r_dp_vld[r_rd_addr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_left    <= n_left;
        r_diag    <= n_diag;
        r_rd_addr <= rd_addr;
        r_rd_vld  <= r_dp_vld[rd_addr];
        if (unit_ld) begin
            r_unit <= i_code_unit;
        end
        if (dist_ld) begin
            r_distance <= 6'(eff);
            r_overflow <= r_ovf;
        end
        if (score_ld) begin
            r_score <= score_val;
        end
    end

    // First string store
    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            fs_mem[r_n[AW-1:0]] <= i_code_unit;
        end
        r_fs_q <= fs_mem[fs_ra];
    end

    // DP column store
    always_ff @(posedge i_clk) begin
        if (dp_we) begin
            dp_mem[r_rd_addr] <= dp_wd;
        end
        r_dp_q <= dp_mem[rd_addr];
    end

    assign o_done     = r_done;
    assign o_distance = r_distance;
    assign o_score    = r_score;
    assign o_overflow = r_overflow;

    // Result strobe only when idle again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Score is either the empty marker or a percent
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_score == SCORE_EMPTY) || (o_score >= 8'sd0 && o_score <= SCORE_FULL))
        else $error("score out of range");

    // Column sweep never reads past the first string
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL) |-> (r_rd_addr <= r_n))
        else $error("column sweep past first length");

    // A result follows only the finish states
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_FIN) || ($past(r_state) == S_DIV))
        else $error("result without finish");

endmodule

/* tb/edit_distance_similarity_core_tb.sv */
// Testbench for edit_distance_similarity_core: drives string and finish requests,
// predicts each distance/score result and checks it as it is shown.
// Depends on edc_pkg and the RTL of the core.
module edit_distance_similarity_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import edc_pkg::*;

    localparam int MAX_LEN      = 32;
    localparam int UNIT_COUNT   = 750;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [5:0]        distance;
        logic signed [7:0] score;
        logic              overflow;
    } t_similarity;

    // Running edit distance over both strings, plus the queue of results owed
    class edit_distance_predictor;
        logic [CODE_W-1:0] stored_units[MAX_LEN];
        int unsigned       column[MAX_LEN+1];
        int unsigned       first_len;
        int unsigned       second_len;
        bit                second_phase;
        bit                dropped;
        t_similarity       pending_results[$];
        int unsigned       error_count;

        function new();
            error_count = 0;
            clear();
        endfunction

        function void clear();
            for (int k = 0; k <= MAX_LEN; k++) column[k] = k;
            first_len    = 0;
            second_len   = 0;
            second_phase = 1'b0;
            dropped      = 1'b0;
        endfunction

        // Advance the DP column by one unit of the second string
        function void advance_column(logic [CODE_W-1:0] code_unit);
            int unsigned diag;
            int unsigned above;
            int unsigned best;
            int unsigned cost;
            diag = column[0];
            column[0] = second_len + 1;
            for (int i = 1; i <= first_len; i++) begin
                above = column[i];
                cost  = (stored_units[i-1] == code_unit) ? 0 : 1;
                best  = column[i-1] + 1;
                if (above + 1 < best) best = above + 1;
                if (diag + cost < best) best = diag + cost;
                column[i] = best;
                diag = above;
            end
        endfunction

        // Apply one accepted request; a finish queues the result it owes
        function void note_request(logic [1:0] command, logic [CODE_W-1:0] code_unit);
            t_similarity r;
            int unsigned longer;
            int unsigned quotient;
            case (command)
                CMD_FIRST: begin
                    if (!second_phase) begin
                        if (first_len >= MAX_LEN) begin
                            dropped = 1'b1;
                        end else begin
                            stored_units[first_len] = code_unit;
                            first_len++;
                        end
                    end
                end
                CMD_SECOND: begin
                    second_phase = 1'b1;
                    if (second_len >= MAX_LEN) begin
                        dropped = 1'b1;
                    end else begin
                        advance_column(code_unit);
                        second_len++;
                    end
                end
                CMD_FINISH: begin
                    r.distance = 6'(column[first_len]);
                    r.overflow = dropped;
                    if (first_len == 0 || second_len == 0) begin
                        r.score = SCORE_EMPTY;
                    end else begin
                        longer   = (first_len > second_len) ? first_len : second_len;
                        quotient = (PCT * column[first_len]) / longer;
                        r.score  = (quotient >= PCT) ? 8'sd0 : SCORE_FULL - 8'(quotient);
                    end
                    pending_results.push_back(r);
                    clear();
                end
                default: ;
            endcase
        endfunction

        // Compare a shown result with the oldest one owed
        function void check_result(logic [5:0] distance, logic signed [7:0] score,
                                   logic overflow);
            t_similarity want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: distance %0d score %0d overflow %0d",
                         $time, distance, score, overflow);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            if (distance !== want.distance) begin
                $display("%0t: distance mismatch: expected %0d, actual %0d",
                         $time, want.distance, distance);
                error_count++;
            end
            if (score !== want.score) begin
                $display("%0t: score mismatch: expected %0d, actual %0d",
                         $time, want.score, score);
                error_count++;
            end
            if (overflow !== want.overflow) begin
                $display("%0t: overflow mismatch: expected %0d, actual %0d",
                         $time, want.overflow, overflow);
                error_count++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic [1:0]               i_command;
    logic [CODE_W-1:0]        i_code_unit;
    logic                     busy;
    logic                     o_done;
    logic [5:0]               o_distance;
    logic signed [7:0]        o_score;
    logic                     o_overflow;

    edit_distance_predictor   similarity_model = new();
    logic [CODE_W-1:0]        unit_pool[4];
    bit                       idle_enabled = 1'b1;
    int unsigned              quiet_cycles = 0;
    int unsigned              sent_items = 0;

    edit_distance_similarity_core #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_command  (i_command),
        .i_code_unit(i_code_unit),
        .busy       (busy),
        .o_done     (o_done),
        .o_distance (o_distance),
        .o_score    (o_score),
        .o_overflow (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Check shown results first, then note any request taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) similarity_model.check_result(o_distance, o_score, o_overflow);
            if (start && !busy) similarity_model.note_request(i_command, i_code_unit);
        end
    end

    // Abort when neither a request nor a result has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("edit_distance_similarity_core_tb: done, errors");
            $finish;
        end
    end

    // Now and then hold off for a random gap, then present a request until it is taken
    task automatic send_request(input logic [1:0] command, input logic [CODE_W-1:0] code_unit);
        int unsigned gap;
        if (idle_enabled && $urandom_range(99) < 17) begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(3, 1);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start       = 1'b1;
        i_command   = command;
        i_code_unit = code_unit;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic void refresh_pool();
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(5))
                0:       unit_pool[k] = '0;
                1:       unit_pool[k] = '1;
                default: unit_pool[k] = CODE_W'($urandom_range(65535));
            endcase
        end
    endfunction

    // Mostly draw from a small pool so that units match often
    function automatic logic [CODE_W-1:0] pick_unit();
        if ($urandom_range(3) != 0) return unit_pool[$urandom_range(3)];
        return CODE_W'($urandom_range(65535));
    endfunction

    // Mostly short strings, some empty, a few past the length limit
    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)  return 0;
        if (roll < 80) return $urandom_range(8, 1);
        if (roll < 90) return $urandom_range(29, 9);
        return $urandom_range(MAX_LEN + 2, MAX_LEN - 2);
    endfunction

    // Send one first string, one second string and a finish, with some noise
    task automatic send_string_pair();
        logic [CODE_W-1:0] first_units[$];
        logic [CODE_W-1:0] code_unit;
        int unsigned       first_count;
        int unsigned       second_count;
        bit                mirror;
        first_count  = pick_length();
        second_count = pick_length();
        mirror       = ($urandom_range(9) < 3);
        refresh_pool();
        for (int i = 0; i < first_count; i++) begin
            code_unit = pick_unit();
            first_units.push_back(code_unit);
            send_request(CMD_FIRST, code_unit);
            if ($urandom_range(19) == 0)
                send_request(CMD_UNUSED, CODE_W'($urandom_range(65535)));
        end
        for (int j = 0; j < second_count; j++) begin
            if (mirror && j < first_count && $urandom_range(9) != 0) code_unit = first_units[j];
            else code_unit = pick_unit();
            send_request(CMD_SECOND, code_unit);
            // drop a late first-string unit in now and then; it must be ignored
            if ($urandom_range(19) == 0) send_request(CMD_FIRST, pick_unit());
        end
        send_request(CMD_FINISH, CODE_W'($urandom_range(65535)));
        sent_items += first_count + second_count + 1;
    endtask

    initial begin
        int unsigned burst;
        logic [1:0]  command;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_command   = CMD_FIRST;
        i_code_unit = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty strings on both sides, then on one side each
        send_request(CMD_FINISH, 16'h0000);
        send_request(CMD_FIRST, 16'h0000);
        send_request(CMD_FIRST, 16'hFFFF);
        send_request(CMD_FINISH, 16'hFFFF);
        send_request(CMD_SECOND, 16'hFFFF);
        send_request(CMD_FINISH, 16'h0000);
        // exact match, with an unused command and a late first unit mixed in
        send_request(CMD_FIRST, 16'hAAAA);
        send_request(CMD_FIRST, 16'h5555);
        send_request(CMD_UNUSED, 16'hFFFF);
        send_request(CMD_SECOND, 16'hAAAA);
        send_request(CMD_SECOND, 16'h5555);
        send_request(CMD_FIRST, 16'h1234);
        send_request(CMD_FINISH, 16'h0000);
        // distance equal to the longer length gives a zero score
        send_request(CMD_FIRST, 16'h0001);
        send_request(CMD_FIRST, 16'h0002);
        send_request(CMD_FIRST, 16'h0003);
        send_request(CMD_SECOND, 16'h8000);
        send_request(CMD_FINISH, 16'h0000);
        // partial match with a truncated quotient
        send_request(CMD_FIRST, 16'h7FFF);
        send_request(CMD_SECOND, 16'h7FFE);
        send_request(CMD_SECOND, 16'h7FFF);
        send_request(CMD_SECOND, 16'h7FFF);
        send_request(CMD_FINISH, 16'h0000);

        // random part: mostly well-formed string pairs, some command noise
        while (sent_items < UNIT_COUNT) begin
            idle_enabled = !(sent_items >= 300 && sent_items < 450);
            if ($urandom_range(99) < 80) begin
                send_string_pair();
            end else begin
                burst = $urandom_range(6, 1);
                for (int b = 0; b < burst; b++) begin
                    command = 2'($urandom_range(3));
                    send_request(command, CODE_W'($urandom_range(65535)));
                    if (command != CMD_UNUSED) sent_items++;
                end
            end
        end
        send_request(CMD_FINISH, 16'h0000);

        // drop start, wait out the owed results, then a short quiet spell
        @(negedge i_clk);
        start = 1'b0;
        while (similarity_model.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (similarity_model.error_count == 0) begin
            $display("edit_distance_similarity_core_tb: done, clean");
        end else begin
            $display("edit_distance_similarity_core_tb: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/edc_pkg.sv
sv/edc_step.sv
sv/edc_div.sv
sv/edit_distance_similarity_core.sv
tb/edit_distance_similarity_core_tb.sv
